>>> hw/rtl/csd_pkg.sv
package csd_pkg;

  // Sample and baseline formats.
  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int MAG_W         = SAMPLE_WIDTH;
  localparam int BASE_W        = SAMPLE_WIDTH + FRACTION_BITS;

  // Configuration registers are 16 bits wide; alpha is unsigned Q0.16.
  localparam int CFG_W      = 16;
  localparam int ALPHA_BITS = 16;
  localparam int PROD_W     = ALPHA_BITS + BASE_W;
  localparam int LIM_W      = ((CFG_W > SAMPLE_WIDTH) ? CFG_W : SAMPLE_WIDTH)
                              + FRACTION_BITS + 1;

  typedef enum logic [1:0] {
    REG_RISE_THRESHOLD   = 2'd0,
    REG_HITS_NEEDED      = 2'd1,
    REG_SMOOTHING_FACTOR = 2'd2,
    REG_WARMUP_SAMPLES   = 2'd3
  } cfg_index_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_REARM  = 1'b1
  } kind_t;

  localparam logic [CFG_W-1:0] RISE_THRESHOLD_RESET   = 16'd1024;
  localparam logic [CFG_W-1:0] HITS_NEEDED_RESET      = 16'd3;
  localparam logic [CFG_W-1:0] SMOOTHING_FACTOR_RESET = 16'd655;
  localparam logic [CFG_W-1:0] WARMUP_SAMPLES_RESET   = 16'd50;

endpackage

>>> hw/rtl/current_spike_contact_detector.sv
// A request accepted into the input register moves on to the result register, which
// raises out_valid. Throughput: one request per cycle unless out_stall holds the result;
// the baseline multiply-add and threshold compare settle between the two registers.
// Reset (rst, synchronous, active high): configuration returns to its defaults, the
// baseline, warm-up count, hit run and contact latch clear, and both stages empty.
module current_spike_contact_detector (
  input  logic                                  clk,
  input  logic                                  rst,
  // Sample channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  kind,
  input  logic signed [csd_pkg::SAMPLE_WIDTH-1:0] current_sample,
  input  logic                                  enable,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  touched,
  // Configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [csd_pkg::CFG_W-1:0]             cfg_data
);

  // Configuration registers.
  logic [csd_pkg::CFG_W-1:0] rise_threshold;
  logic [csd_pkg::CFG_W-1:0] hits_needed;
  logic [csd_pkg::CFG_W-1:0] smoothing_factor;
  logic [csd_pkg::CFG_W-1:0] warmup_samples;

  // Detector state.
  logic [csd_pkg::BASE_W-1:0] baseline;
  logic [csd_pkg::CFG_W-1:0]  warmup_count;
  logic [csd_pkg::CFG_W-1:0]  hit_run;
  logic                       contact_latched;

  logic [csd_pkg::BASE_W-1:0] baseline_next;
  logic [csd_pkg::CFG_W-1:0]  warmup_count_next;
  logic [csd_pkg::CFG_W-1:0]  hit_run_next;
  logic                       contact_latched_next;

  // Input register stage.
  logic                            s1_valid;
  csd_pkg::kind_t                  s1_kind;
  logic [csd_pkg::SAMPLE_WIDTH-1:0] s1_sample;
  logic                            s1_enable;

  logic advance;

  // The configuration port never waits; the user must write only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_threshold   <= csd_pkg::RISE_THRESHOLD_RESET;
      hits_needed      <= csd_pkg::HITS_NEEDED_RESET;
      smoothing_factor <= csd_pkg::SMOOTHING_FACTOR_RESET;
      warmup_samples   <= csd_pkg::WARMUP_SAMPLES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (csd_pkg::cfg_index_t'(cfg_index))
        csd_pkg::REG_RISE_THRESHOLD:   rise_threshold   <= cfg_data;
        csd_pkg::REG_HITS_NEEDED:      hits_needed      <= cfg_data;
        csd_pkg::REG_SMOOTHING_FACTOR: smoothing_factor <= cfg_data;
        csd_pkg::REG_WARMUP_SAMPLES:   warmup_samples   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The item in the input register moves on whenever the result register is empty
  // or its result is being taken this cycle. A new request can enter the input
  // register in the same cycle, so a steady stream flows at one request per cycle while results are taken.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind   <= csd_pkg::kind_t'(kind);
      s1_sample <= current_sample;
      s1_enable <= enable;
    end
  end

  // Datapath. The magnitude is exact: the most negative sample wraps to 2^(W-1),
  // which reads correctly as an unsigned value of the same width.
  logic [csd_pkg::MAG_W-1:0]  magnitude;
  logic [csd_pkg::BASE_W-1:0] cur;
  logic                       rising;
  logic [csd_pkg::BASE_W-1:0] diff;
  logic [csd_pkg::PROD_W-1:0] prod;
  logic [csd_pkg::PROD_W-1:0] prod_rounded;
  logic [csd_pkg::BASE_W-1:0] step_down;
  logic [csd_pkg::BASE_W-1:0] step_up;
  logic [csd_pkg::BASE_W-1:0] baseline_ema;
  logic [csd_pkg::LIM_W-1:0]  limit;
  logic                       is_hit;
  logic [csd_pkg::CFG_W-1:0]  need;
  logic [csd_pkg::CFG_W-1:0]  hit_run_grown;

  assign magnitude = s1_sample[csd_pkg::SAMPLE_WIDTH-1] ? (~s1_sample + 1'b1) : s1_sample;
  assign cur       = {magnitude, {csd_pkg::FRACTION_BITS{1'b0}}};

  // The average steps toward the sample: truncated when rising, rounded up when
  // falling, so the baseline always lands between its old value and the sample.
  assign rising       = (cur >= baseline);
  assign diff         = rising ? (cur - baseline) : (baseline - cur);
  assign prod         = {{csd_pkg::BASE_W{1'b0}}, smoothing_factor}
                        * {{csd_pkg::ALPHA_BITS{1'b0}}, diff};
  assign prod_rounded = prod + {{csd_pkg::BASE_W{1'b0}}, {csd_pkg::ALPHA_BITS{1'b1}}};
  assign step_down    = prod[csd_pkg::ALPHA_BITS +: csd_pkg::BASE_W];
  assign step_up      = prod_rounded[csd_pkg::ALPHA_BITS +: csd_pkg::BASE_W];
  assign baseline_ema = rising ? (baseline + step_down) : (baseline - step_up);

  // A hits_needed of zero behaves as one.
  assign need          = (hits_needed == '0) ? csd_pkg::CFG_W'(1) : hits_needed;
  assign hit_run_grown = (hit_run < need) ? (hit_run + 1'b1) : hit_run;

  always_comb begin
    baseline_next        = baseline;
    warmup_count_next    = warmup_count;
    hit_run_next         = hit_run;
    contact_latched_next = contact_latched;
    limit                = '0;
    is_hit               = 1'b0;

    if (s1_kind == csd_pkg::KIND_REARM) begin
      baseline_next        = '0;
      warmup_count_next    = '0;
      hit_run_next         = '0;
      contact_latched_next = 1'b0;
    end else if (!s1_enable) begin
      // Disabled samples only break the hit run.
      hit_run_next = '0;
    end else begin
      // With the warm-up count at zero the sample seeds the baseline; afterwards
      // the baseline tracks only while no contact is latched.
      if (warmup_count == '0) begin
        baseline_next = cur;
      end else if (!contact_latched) begin
        baseline_next = baseline_ema;
      end

      limit  = csd_pkg::LIM_W'(baseline_next)
               + csd_pkg::LIM_W'({rise_threshold, {csd_pkg::FRACTION_BITS{1'b0}}});
      is_hit = (csd_pkg::LIM_W'(cur) > limit);

      if (warmup_count < warmup_samples) begin
        warmup_count_next = warmup_count + 1'b1;
        hit_run_next      = '0;
      end else if (is_hit) begin
        hit_run_next = hit_run_grown;
        if (hit_run_grown >= need) begin
          contact_latched_next = 1'b1;
        end
      end else begin
        hit_run_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline        <= '0;
      warmup_count    <= '0;
      hit_run         <= '0;
      contact_latched <= 1'b0;
    end else if (advance) begin
      baseline        <= baseline_next;
      warmup_count    <= warmup_count_next;
      hit_run         <= hit_run_next;
      contact_latched <= contact_latched_next;
    end
  end

  // Result register: holds the latched flag after each request until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      touched <= contact_latched_next;
    end
  end

`ifndef ASSERT_OFF
  a_rearm_clears_result: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_kind == csd_pkg::KIND_REARM) |=> (out_valid && !touched))
    else $error("rearm request did not return a cleared contact flag");

  a_latch_holds: assert property (@(posedge clk) disable iff (rst)
    (contact_latched && !(advance && s1_kind == csd_pkg::KIND_REARM)) |=> contact_latched)
    else $error("contact latch dropped without a rearm request");

  a_state_moves_on_advance: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(baseline) && $stable(hit_run) && $stable(warmup_count)))
    else $error("detector state changed with no request advancing");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while the pipeline could move");
`endif

endmodule
